[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes of the sorted priority queue
// Entry and command structs passed from the control to the cell row,
// opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int KeyWidth   = 32;
   localparam int PrioWidth  = 32;
   localparam int StatWidth  = 2;
   localparam int CountWidth = 5;

   // request kinds
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   // result status codes
   localparam logic [StatWidth-1:0] STAT_DONE  = 2'd0;
   localparam logic [StatWidth-1:0] STAT_EMPTY = 2'd1;
   localparam logic [StatWidth-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic signed [KeyWidth-1:0]  key;
      logic signed [PrioWidth-1:0] prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      insert;   // insert taken (queue not full)
      logic      extract;  // extract taken (queue not empty)
      entry_type entry;    // new entry of an insert
   } cmd_type;

endpackage

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted row
// Holds one entry, compares it with the broadcast priority, and takes the
// new entry, its left neighbor's or its right neighbor's entry, or keeps its own.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic              clock,
   input  logic              strict_cmp,   // head slot: only a strictly higher prio goes first
   input  logic              occupied,
   input  spq_pkg::cmd_type  cmd,
   input  logic              left_flag,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic              flag
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      prio_gt;
   logic      prio_ge;

   // insert position marker: new entry belongs at or before this slot
   assign prio_gt = cmd.entry.prio >  entry_ff.prio;
   assign prio_ge = cmd.entry.prio >= entry_ff.prio;
   assign flag    = !occupied || (strict_cmp ? prio_gt : prio_ge);

   // pick next content
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (flag && !left_flag) begin
            entry_in = cmd.entry;
         end else if (flag) begin
            entry_in = left_entry;
         end
      end else if (cmd.extract) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[sv/sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_core - bounded priority queue, sorted shift row
// Entries sit in a row of cells in descending priority order. An insert
// shifts the tail right and drops the new entry in place; an extract shifts
// the whole row left. Each item yields one result with status and new head.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                       | tuser
//  --------+-----+--------------------------------------------------+---------
//  req     | in  | entry_key[31:0], entry_priority[63:32]          | opcode
//  rsp     | out | status[1:0], head_valid[2], head_key[34:3],     | -
//          |     | head_priority[66:35], entry_count[71:67]        |
//
//  One item per cycle unless a waiting result stalls on rsp_tready: every cell
//  compares its priority with the incoming one in parallel and shifts in the
//  same cycle, so the clock is set by a single 32-bit compare plus a 4-way select per cell.
//  Result appears in the cycle after acceptance, in an output register.
//  req_tready is low only while a result waits and rsp_tready is low.
//  Synchronous reset empties the queue; stored entries are not cleared.
//
module sorted_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // entry_key[31:0], entry_priority[63:32]
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // status, head_valid, head_key, head_priority, entry_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            rsp_valid_ff;
   logic [71:0]     rsp_data_ff;
   logic [71:0]     rsp_data_in;
   logic            accept;
   logic            is_full;
   logic            is_empty;
   logic [StatWidth-1:0] status;
   cmd_type         cmd;
   entry_type       cell_entry [CAPACITY];
   logic            cell_flag  [CAPACITY];
   entry_type       head_in;
   logic [CW+4:0]   count_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CW'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   // command broadcast
   always_comb begin
      cmd.insert     = accept && (req_tuser[0] == OP_INSERT) && !is_full;
      cmd.extract    = accept && (req_tuser[0] == OP_EXTRACT) && !is_empty;
      cmd.entry.key  = req_tdata[31:0];
      cmd.entry.prio = req_tdata[63:32];
   end

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      spq_cell u_cell (
         .clock       (clock),
         .strict_cmp  (i == 0),
         .occupied    (count_ff > IDX),
         .cmd         (cmd),
         .left_flag   ((i == 0) ? 1'b0 : cell_flag[(i == 0) ? 0 : i-1]),
         .left_entry  ((i == 0) ? cmd.entry : cell_entry[(i == 0) ? 0 : i-1]),
         .right_entry (cell_entry[(i == CAPACITY-1) ? i : i+1]),
         .entry       (cell_entry[i]),
         .flag        (cell_flag[i])
      );
   end

   // occupancy and status
   always_comb begin
      count_in = count_ff;
      status   = STAT_DONE;
      if (accept) begin
         if (req_tuser[0] == OP_INSERT) begin
            if (is_full) begin
               status = STAT_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   // head after the operation
   always_comb begin
      head_in = cell_entry[0];
      if (cmd.insert && cell_flag[0]) begin
         head_in = cmd.entry;
      end else if (cmd.extract) begin
         head_in = cell_entry[1];
      end
      if (count_in == '0) begin
         head_in = '0;
      end
   end

   assign count_ext   = {5'b0, count_in};
   assign rsp_data_in = {count_ext[4:0], head_in.prio, head_in.key,
                         (count_in != '0), status};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser[0] == OP_EXTRACT) && is_empty |=> $stable(count_ff))
      else $error("extract from empty queue changed occupancy");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser[0] == OP_INSERT) && is_full |=> $stable(count_ff))
      else $error("insert into full queue changed occupancy");

   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tdata[2] == (count_ff != '0))
      else $error("head_valid disagrees with occupancy");

endmodule
